FILE: design/ftsl_pkg.sv
// ftsl_pkg: shared types and codes for the file table sector lookup block
// used by ftsl_cell and file_table_sector_lookup_unit; no dependencies
package ftsl_pkg;

    // command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DENIED    = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    // access right bits
    localparam int RIGHT_READ_BIT  = 0;
    localparam int RIGHT_WRITE_BIT = 1;

    typedef struct packed {
        logic [1:0]  command;
        logic [6:0]  entry_index;
        logic [63:0] name_high;
        logic [63:0] name_low;
        logic [27:0] first_lba;
        logic [15:0] byte_size;
        logic [1:0]  access_rights;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  match_slot;
        logic [27:0] sector_address;
        logic        has_sector;
        logic [15:0] file_bytes;
        logic        is_last;
    } t_out_word;

    // broadcast write to the row of cells
    typedef struct packed {
        logic        load;
        logic        set_size;
        logic [63:0] name_high;
        logic [63:0] name_low;
        logic [27:0] start;
        logic [15:0] size;
        logic [1:0]  rights;
    } t_cell_cmd;

    // search token handed from cell to cell (slot travels beside it)
    typedef struct packed {
        logic        active;
        logic        found;
        logic [27:0] start;
        logic [15:0] size;
        logic [1:0]  rights;
    } t_carry;

endpackage

FILE: design/ftsl_cell.sv
// ftsl_cell: one table entry plus one stage of the search chain
// depends on ftsl_pkg
module ftsl_cell #(
    parameter int SLOT_W     = 7,
    parameter int CELL_INDEX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ftsl_pkg::t_cell_cmd i_cmd,
    input  logic [6:0]          i_load_index,
    input  logic [SLOT_W-1:0]   i_set_slot,
    input  logic [63:0]         i_key_high,
    input  logic [63:0]         i_key_low,
    input  ftsl_pkg::t_carry    i_carry,
    input  logic [SLOT_W-1:0]   i_carry_slot,
    output ftsl_pkg::t_carry    o_carry,
    output logic [SLOT_W-1:0]   o_carry_slot
);
    import ftsl_pkg::*;

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_INDEX);

    logic [63:0]       r_name_high;
    logic [63:0]       r_name_low;
    logic [27:0]       r_start;
    logic [15:0]       r_size;
    logic [1:0]        r_rights;
    t_carry            r_carry;
    logic [SLOT_W-1:0] r_carry_slot;

    logic w_load_hit;
    logic w_size_hit;
    logic w_match;

    assign w_load_hit = i_cmd.load && (32'(i_load_index) == 32'(CELL_INDEX));
    assign w_size_hit = i_cmd.set_size && (i_set_slot == MY_SLOT);
    assign w_match    = (r_name_high == i_key_high) && (r_name_low == i_key_low);

    // entry store, zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_high <= '0;
            r_name_low  <= '0;
            r_start     <= '0;
            r_size      <= '0;
            r_rights    <= '0;
        end else if (w_load_hit) begin
            r_name_high <= i_cmd.name_high;
            r_name_low  <= i_cmd.name_low;
            r_start     <= i_cmd.start;
            r_size      <= i_cmd.size;
            r_rights    <= i_cmd.rights;
        end else if (w_size_hit) begin
            r_size <= i_cmd.size;
        end
    end

    // first match wins: once found, the token passes untouched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry.active <= 1'b0;
        end else begin
            r_carry.active <= i_carry.active;
        end
        if (i_carry.active && !i_carry.found && w_match) begin
            r_carry.found  <= 1'b1;
            r_carry.start  <= r_start;
            r_carry.size   <= r_size;
            r_carry.rights <= r_rights;
            r_carry_slot   <= MY_SLOT;
        end else begin
            r_carry.found  <= i_carry.found;
            r_carry.start  <= i_carry.start;
            r_carry.size   <= i_carry.size;
            r_carry.rights <= i_carry.rights;
            r_carry_slot   <= i_carry_slot;
        end
    end

    assign o_carry      = r_carry;
    assign o_carry_slot = r_carry_slot;

endmodule

FILE: design/file_table_sector_lookup_unit.sv
// file_table_sector_lookup_unit: top level, row of table cells and run sequencer
// depends on ftsl_pkg and ftsl_cell
//
// usage:
//   input channel i_in_valid / o_in_ready carries one command word (t_in_word)
//   output channel o_out_valid / i_out_ready carries result words (t_out_word)
//   a load word writes one table entry at once and gives no result
//   command 3 is taken and dropped
//   a read or write word sends a search token down the row of TABLE_ENTRIES
//   cells, one cell per cycle; when the token leaves the row, one result word
//   per cycle follows while the output register is free, one per sector
//   of the run (up to MAX_RUN_SECTORS), or a single word for not found,
//   denied, too large or empty files; is_last marks the final word
//   one request is in flight at a time: a read or write occupies the block
//   until its last result word is emitted; a load leaves the block idle
//   the next word is taken while the last result still sits in the output
//   register; a stalled receiver holds the sequencer on the current word
//   reset clears the whole table to zero names, zero sizes and no rights
module file_table_sector_lookup_unit #(
    parameter int TABLE_ENTRIES   = 128,
    parameter int SECTOR_BYTES    = 512,
    parameter int MAX_RUN_SECTORS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ftsl_pkg::t_in_word  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ftsl_pkg::t_out_word o_out
);
    import ftsl_pkg::*;

    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LIMIT_BYTES = MAX_RUN_SECTORS * SECTOR_BYTES;
    localparam logic [15:0] SECTOR_BYTES_W = 16'(SECTOR_BYTES);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_EMIT   = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic              r_launch;
    logic              r_is_write;
    logic [63:0]       r_key_high;
    logic [63:0]       r_key_low;
    logic [15:0]       r_req_bytes;

    logic [1:0]        r_stat, n_stat;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [27:0]       r_sector, n_sector;
    logic [15:0]       r_bytes, n_bytes;
    logic [15:0]       r_remain, n_remain;
    logic              r_single, n_single;

    logic              r_out_valid;
    t_out_word         r_out;

    t_carry            w_carry [0:TABLE_ENTRIES];
    logic [SLOT_W-1:0] w_slot  [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_active;
    t_cell_cmd         w_cmd;
    t_carry            w_tail;
    logic [SLOT_W-1:0] w_tail_slot;

    logic      w_in_accept;
    logic      w_out_free;
    logic      w_emit;
    logic      w_emit_last;
    t_out_word w_word;
    logic      w_decide;
    logic      w_allowed;
    logic [15:0] w_size;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // search token enters the row in the cycle after the request is taken
    assign w_carry[0].active = r_launch;
    assign w_carry[0].found  = 1'b0;
    assign w_carry[0].start  = '0;
    assign w_carry[0].size   = '0;
    assign w_carry[0].rights = '0;
    assign w_slot[0]         = '0;

    assign w_tail      = w_carry[TABLE_ENTRIES];
    assign w_tail_slot = w_slot[TABLE_ENTRIES];
    assign w_decide    = (r_state == S_SEARCH) && w_tail.active;

    assign w_size    = r_is_write ? r_req_bytes : w_tail.size;
    assign w_allowed = r_is_write ? w_tail.rights[RIGHT_WRITE_BIT]
                                  : w_tail.rights[RIGHT_READ_BIT];

    // broadcast: loads from the input, size store back from the decision
    always_comb begin
        w_cmd.load      = w_in_accept && (i_in.command == CMD_LOAD);
        w_cmd.set_size  = w_decide && r_is_write && w_tail.found && w_allowed
                          && (32'(r_req_bytes) <= 32'(LIMIT_BYTES));
        w_cmd.name_high = i_in.name_high;
        w_cmd.name_low  = i_in.name_low;
        w_cmd.start     = i_in.first_lba;
        w_cmd.size      = w_cmd.load ? i_in.byte_size : r_req_bytes;
        w_cmd.rights    = i_in.access_rights;
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ftsl_cell #(
            .SLOT_W    (SLOT_W),
            .CELL_INDEX(g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_load_index(i_in.entry_index),
            .i_set_slot  (w_tail_slot),
            .i_key_high  (r_key_high),
            .i_key_low   (r_key_low),
            .i_carry     (w_carry[g]),
            .i_carry_slot(w_slot[g]),
            .o_carry     (w_carry[g+1]),
            .o_carry_slot(w_slot[g+1])
        );
        assign w_active[g] = w_carry[g+1].active;
    end

    // one result word per cycle while the output register is free
    assign w_emit      = (r_state == S_EMIT) && w_out_free;
    assign w_emit_last = r_single || (r_remain <= SECTOR_BYTES_W);

    always_comb begin
        w_word.status         = r_stat;
        w_word.match_slot     = 7'(r_slot);
        w_word.sector_address = r_single ? 28'd0 : r_sector;
        w_word.has_sector     = !r_single;
        w_word.file_bytes     = r_bytes;
        w_word.is_last        = w_emit_last;
    end

    always_comb begin
        n_state  = r_state;
        n_stat   = r_stat;
        n_slot   = r_slot;
        n_sector = r_sector;
        n_bytes  = r_bytes;
        n_remain = r_remain;
        n_single = r_single;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept && (i_in.command == CMD_READ
                                    || i_in.command == CMD_WRITE)) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_decide) begin
                    n_state  = S_EMIT;
                    n_slot   = w_tail_slot;
                    n_bytes  = w_size;
                    n_sector = w_tail.start;
                    n_remain = w_size;
                    n_single = 1'b1;
                    if (!w_tail.found) begin
                        n_stat  = ST_NOT_FOUND;
                        n_slot  = '0;
                        n_bytes = '0;
                    end else if (!w_allowed) begin
                        n_stat = ST_DENIED;
                    end else if (32'(w_size) > 32'(LIMIT_BYTES)) begin
                        n_stat = ST_TOO_LARGE;
                    end else begin
                        n_stat   = ST_OK;
                        n_single = (w_size == 16'd0);
                    end
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    if (w_emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_remain = r_remain - SECTOR_BYTES_W;
                        n_sector = r_sector + 28'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_in_accept && (i_in.command == CMD_READ
                                        || i_in.command == CMD_WRITE);
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_stat   <= n_stat;
        r_slot   <= n_slot;
        r_sector <= n_sector;
        r_bytes  <= n_bytes;
        r_remain <= n_remain;
        r_single <= n_single;
        if (w_in_accept) begin
            r_is_write  <= (i_in.command == CMD_WRITE);
            r_key_high  <= i_in.name_high;
            r_key_low   <= i_in.name_low;
            r_req_bytes <= i_in.byte_size;
        end
        if (w_emit) begin
            r_out <= w_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // only one search token lives in the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_active) <= 1)
        else $error("more than one search token in the cell row");

    // the token only leaves the row while a search is pending
    a_tail_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.active |-> (r_state == S_SEARCH))
        else $error("search token arrived outside a search");

    // size write-back only for a found entry at the end of the row
    a_set_size_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.set_size |-> (w_tail.active && w_tail.found))
        else $error("size write-back without a matching entry");

    // leaving the emit state leaves the last word waiting at the output
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_state == S_EMIT) |-> (o_out_valid && o_out.is_last))
        else $error("run ended without a last word at the output");

endmodule
